// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers included by the rtl top module
// each macro expands to one labelled concurrent assertion on the rising edge of clk,
// switched off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cm_pkg
// types and codes for the byte-level i2c master bit engine
// ---------------------------------------------------------------------------
package i2cm_pkg;

	// input action field
	typedef logic [2:0] action_t;

	// action codes, also used as operation codes (idle shares the tick code)
	localparam action_t ACT_TICK  = 3'd0;
	localparam action_t ACT_START = 3'd1;
	localparam action_t ACT_WRITE = 3'd2;
	localparam action_t ACT_READ  = 3'd3;
	localparam action_t ACT_STOP  = 3'd4;
	localparam action_t OP_IDLE   = 3'd0;

	// phase step within a bit or a start/stop sequence
	typedef logic [1:0] step_t;
	localparam step_t STEP_SET  = 2'd0;
	localparam step_t STEP_HIGH = 2'd1;
	localparam step_t STEP_LOW  = 2'd2;

	// timing
	typedef logic [15:0] ticks_t;
	localparam ticks_t PHASE_TICKS_RST = 16'd500;

	// bits per transfer: eight data bits and one ack bit
	localparam int unsigned BITS_PER_XFER = 9;

endpackage

// ===== hdl/i2c_master_bit_engine_top.sv =====
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_top
// byte-level i2c master: start, write byte, read byte and stop commands,
// stepped by tick transactions that carry the sampled sda level.
// an accepted transaction goes to the input register, then to the result register.
// throughput: one transaction per cycle unless out_ready stalls; single update stage.
// reset: bus lines released, engine idle, phase length 500 ticks, rx byte and nack clear.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  i2cm_pkg::action_t action,
	input  logic [7:0]        tx_data,
	input  logic              ack_flag,
	input  logic              sda_in,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              scl_out,
	output logic              sda_out,
	output logic              busy_res,
	output logic              done_res,
	output logic [7:0]        rx_data,
	output logic              nack
);
	import i2cm_pkg::*;

	`include "assert_macros.svh"

	// input stage
	logic        valid_s1;
	action_t     action_s1;
	logic [7:0]  tx_s1;
	logic        ackf_s1;
	logic        sample_s1;

	// engine state
	ticks_t      phase_q;
	action_t     op_q;
	step_t       step_q;
	logic [3:0]  bit_idx_q;
	logic [7:0]  shift_q;
	ticks_t      tick_q;
	logic        scl_q;
	logic        sda_q;
	logic        ack_mode_q;
	logic        nack_q;
	logic [7:0]  rx_q;

	// result register
	logic        res_valid_q;
	logic        res_scl_q;
	logic        res_sda_q;
	logic        res_busy_q;
	logic        res_done_q;
	logic [7:0]  res_rx_q;
	logic        res_nack_q;

	// next state
	action_t     op_d;
	step_t       step_d;
	logic [3:0]  bit_idx_d;
	logic [7:0]  shift_d;
	ticks_t      tick_d;
	logic        scl_d;
	logic        sda_d;
	logic        ack_mode_d;
	logic        nack_d;
	logic [7:0]  rx_d;
	logic        done_d;

	logic        advance;
	logic [16:0] tick_sum;
	ticks_t      limit;
	logic [3:0]  bit_next;
	logic        finish;

	// sda level at the start of a bit
	function automatic logic begin_bit_sda(action_t op, logic [3:0] idx,
			logic [7:0] shb, logic ackm);
		logic rd;
		rd = (op == ACT_WRITE) ? (idx >= 4'd8) : (idx < 4'd8);
		if (rd)
			return 1'b1;
		else if (op == ACT_WRITE)
			return shb[3'd7 - idx[2:0]];
		else
			return ~ackm;
	endfunction

	// current bit is sampled from the bus
	function automatic logic bit_is_read(action_t op, logic [3:0] idx);
		return (op == ACT_WRITE) ? (idx >= 4'd8) : (idx < 4'd8);
	endfunction

	// handshakes
	assign advance   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			phase_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			tx_s1     <= tx_data;
			ackf_s1   <= ack_flag;
			sample_s1 <= sda_in;
		end
	end

	// state update for one transaction
	assign limit    = (phase_q == '0) ? ticks_t'(1) : phase_q;
	assign tick_sum = {1'b0, tick_q} + 17'd1;
	assign bit_next = bit_idx_q + 4'd1;

	always_comb begin
		op_d       = op_q;
		step_d     = step_q;
		bit_idx_d  = bit_idx_q;
		shift_d    = shift_q;
		tick_d     = tick_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		ack_mode_d = ack_mode_q;
		nack_d     = nack_q;
		rx_d       = rx_q;
		done_d     = 1'b0;
		finish     = 1'b0;
		if (op_q == OP_IDLE) begin
			// command launch; ticks and unknown codes do nothing
			unique case (action_s1) inside
				ACT_START: begin
					op_d = ACT_START; step_d = STEP_SET; bit_idx_d = '0; tick_d = '0;
					sda_d = 1'b1; scl_d = 1'b1;
				end
				ACT_STOP: begin
					op_d = ACT_STOP; step_d = STEP_SET; bit_idx_d = '0; tick_d = '0;
					sda_d = 1'b0; scl_d = 1'b0;
				end
				ACT_WRITE, ACT_READ: begin
					op_d = action_s1; step_d = STEP_SET; bit_idx_d = '0; tick_d = '0;
					ack_mode_d = ackf_s1;
					shift_d = (action_s1 == ACT_WRITE) ? tx_s1 : 8'd0;
					sda_d = begin_bit_sda(action_s1, 4'd0, shift_d, ackf_s1);
				end
				default: begin
				end
			endcase
		end else if (action_s1 == ACT_TICK) begin
			// tick counting and phase end
			if (tick_sum >= {1'b0, limit}) begin
				tick_d = '0;
				unique case (op_q)
					ACT_START: begin
						if (step_q == STEP_SET) begin
							sda_d = 1'b0; step_d = STEP_HIGH;
						end else begin
							scl_d = 1'b0; finish = 1'b1;
						end
					end
					ACT_STOP: begin
						if (step_q == STEP_SET) begin
							scl_d = 1'b1; step_d = STEP_HIGH;
						end else begin
							sda_d = 1'b1; finish = 1'b1;
						end
					end
					default: begin
						// byte transfer bit phases
						if (step_q == STEP_SET) begin
							scl_d = 1'b1; step_d = STEP_HIGH;
						end else if (step_q == STEP_HIGH) begin
							if (bit_is_read(op_q, bit_idx_q)) begin
								if (op_q == ACT_WRITE)
									nack_d = ack_mode_q & sample_s1;
								else
									shift_d = {shift_q[6:0], sample_s1};
							end
							scl_d = 1'b0; step_d = STEP_LOW;
						end else begin
							bit_idx_d = bit_next; step_d = STEP_SET;
							if (bit_next >= 4'(BITS_PER_XFER)) begin
								if (op_q == ACT_READ)
									rx_d = shift_q;
								finish = 1'b1;
							end else begin
								sda_d = begin_bit_sda(op_q, bit_next, shift_q, ack_mode_q);
							end
						end
					end
				endcase
				if (finish) begin
					op_d = OP_IDLE; step_d = STEP_SET; bit_idx_d = '0; done_d = 1'b1;
				end
			end else begin
				tick_d = tick_sum[15:0];
			end
		end
	end

	// engine state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_IDLE;
			step_q     <= STEP_SET;
			bit_idx_q  <= '0;
			shift_q    <= '0;
			tick_q     <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_mode_q <= 1'b0;
			nack_q     <= 1'b0;
			rx_q       <= '0;
		end else if (advance) begin
			op_q       <= op_d;
			step_q     <= step_d;
			bit_idx_q  <= bit_idx_d;
			shift_q    <= shift_d;
			tick_q     <= tick_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			ack_mode_q <= ack_mode_d;
			nack_q     <= nack_d;
			rx_q       <= rx_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_scl_q  <= scl_d;
			res_sda_q  <= sda_d;
			res_busy_q <= (op_d != OP_IDLE);
			res_done_q <= done_d;
			res_rx_q   <= rx_d;
			res_nack_q <= nack_d;
		end
	end

	assign out_valid = res_valid_q;
	assign scl_out   = res_scl_q;
	assign sda_out   = res_sda_q;
	assign busy_res  = res_busy_q;
	assign done_res  = res_done_q;
	assign rx_data   = res_rx_q;
	assign nack      = res_nack_q;

	// checks
	`ASSERT_IMPLY(a_done_not_busy, out_valid && done_res, !busy_res, "done while still busy")
	`ASSERT_IMPLY(a_idle_clean, op_q == OP_IDLE, step_q == STEP_SET && bit_idx_q == 4'd0, "idle with stale bit state")
	`ASSERT_ALWAYS(a_bit_range, bit_idx_q < 4'(BITS_PER_XFER), "bit index past ack bit")
	`ASSERT_IMPLY(a_stall_cause, !in_ready, valid_s1 && out_valid && !out_ready, "input stalled without a full result")
	`ASSERT_IMPLY(a_seq_steps, op_q == ACT_START || op_q == ACT_STOP, step_q != STEP_LOW, "start or stop in a bit step")

endmodule
